>>> hw/rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// shared codes and field types of the bounded ordered list engine
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int FUNC_W = 4;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;

  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [ST_W-1:0]          status_t;

  localparam func_t FN_INS_HEAD = 4'd0;
  localparam func_t FN_INS_TAIL = 4'd1;
  localparam func_t FN_INS_POS  = 4'd2;
  localparam func_t FN_DEL_HEAD = 4'd3;
  localparam func_t FN_DEL_TAIL = 4'd4;
  localparam func_t FN_DEL_POS  = 4'd5;
  localparam func_t FN_SEARCH   = 4'd6;
  localparam func_t FN_DUMP_FWD = 4'd7;
  localparam func_t FN_DUMP_BWD = 4'd8;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_BADPOS   = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

>>> hw/rtl/bole_mem.sv
// ----------------------------------------------------------------------------
// bole_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bole_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl
// operation sequencer: checks, shift walks, search, dump and result register
// ----------------------------------------------------------------------------
module bole_ctrl #(
  parameter int CAPACITY = 16,
  parameter int IW       = 4,
  parameter int CW       = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bole_pkg::func_t    in_func,
  input  bole_pkg::pos_t     in_position,
  input  bole_pkg::val_t     in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output bole_pkg::status_t  out_status,
  output bole_pkg::val_t     out_value,
  output bole_pkg::pos_t     out_found_position,
  output logic               out_last,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output logic [31:0]        mem_wdata,
  output logic               mem_re,
  output logic [IW-1:0]      mem_raddr,
  input  logic [31:0]        mem_rdata
);
  import bole_pkg::*;

  localparam int LW   = (CW > IW + 1) ? CW : IW + 1;
  localparam int CMPW = ((LW > POS_W) ? LW : POS_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_DUMP = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] lim_r, lim_nxt;
  logic [31:0]   val_r, val_nxt;
  logic          bwd_r, bwd_nxt;
  status_t       st_r, st_nxt;

  logic          ov_r;
  status_t       ost_r;
  val_t          oval_r;
  pos_t          opos_r;
  logic          olast_r;

  logic          load;
  status_t       ld_st;
  val_t          ld_val;
  pos_t          ld_pos;
  logic          ld_last;
  logic          out_free;

  logic [CMPW-1:0] n_w, pos_w, k1_w, tgt_w;
  logic            accept;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign n_w   = CMPW'(cnt_r);
  assign pos_w = CMPW'(in_position);
  assign k1_w  = CMPW'(k_r) + CMPW'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    val_nxt   = val_r;
    bwd_nxt   = bwd_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    mem_waddr = k_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = k_r;
    load      = 1'b0;
    ld_st     = ST_OK;
    ld_val    = '0;
    ld_pos    = '0;
    ld_last   = 1'b1;
    tgt_w     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_item_value;
          unique case (in_func) inside
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
              if (in_func == FN_INS_HEAD) begin
                tgt_w = '0;
              end else if (in_func == FN_INS_TAIL) begin
                tgt_w = n_w;
              end else begin
                tgt_w = pos_w - CMPW'(1);
              end
              state_nxt = S_FIN;
              if (in_func == FN_INS_POS &&
                  (pos_w == '0 || pos_w > n_w + CMPW'(1))) begin
                st_nxt = ST_BADPOS;
              end else if (n_w >= CMPW'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else begin
                st_nxt  = ST_OK;
                cnt_nxt = cnt_r + CW'(1);
                idx_nxt = IW'(tgt_w);
                if (tgt_w == n_w) begin
                  state_nxt = S_PUT;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = IW'(n_w - CMPW'(1));
                  k_nxt     = IW'(n_w - CMPW'(1));
                  state_nxt = S_SHUP;
                end
              end
            end
            FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
              if (in_func == FN_DEL_HEAD) begin
                tgt_w = '0;
              end else if (in_func == FN_DEL_TAIL) begin
                tgt_w = n_w - CMPW'(1);
              end else begin
                tgt_w = pos_w - CMPW'(1);
              end
              state_nxt = S_FIN;
              if (n_w == '0) begin
                st_nxt = ST_EMPTY;
              end else if (in_func == FN_DEL_POS && (pos_w == '0 || pos_w > n_w)) begin
                st_nxt = ST_BADPOS;
              end else begin
                st_nxt  = ST_OK;
                cnt_nxt = cnt_r - CW'(1);
                lim_nxt = IW'(n_w - CMPW'(1));
                if (tgt_w != n_w - CMPW'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = IW'(tgt_w + CMPW'(1));
                  k_nxt     = IW'(tgt_w + CMPW'(1));
                  state_nxt = S_SHDN;
                end
              end
            end
            FN_SEARCH: begin
              if (n_w == '0) begin
                st_nxt    = ST_NOTFOUND;
                state_nxt = S_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                k_nxt     = '0;
                lim_nxt   = IW'(n_w - CMPW'(1));
                state_nxt = S_SRCH;
              end
            end
            FN_DUMP_FWD, FN_DUMP_BWD: begin
              if (n_w == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                bwd_nxt   = (in_func == FN_DUMP_BWD);
                lim_nxt   = IW'(n_w - CMPW'(1));
                mem_re    = 1'b1;
                mem_raddr = (in_func == FN_DUMP_BWD) ? IW'(n_w - CMPW'(1)) : '0;
                k_nxt     = (in_func == FN_DUMP_BWD) ? IW'(n_w - CMPW'(1)) : '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(k1_w);
        if (k_r == idx_r) begin
          state_nxt = S_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_r - IW'(1);
          k_nxt     = k_r - IW'(1);
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = val_r;
        state_nxt = S_FIN;
      end
      S_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = k_r - IW'(1);
        if (k_r == lim_r) begin
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(k1_w);
          k_nxt     = IW'(k1_w);
        end
      end
      S_SRCH: begin
        if (mem_rdata == val_r) begin
          if (out_free) begin
            load      = 1'b1;
            ld_pos    = POS_W'(k1_w);
            state_nxt = S_IDLE;
          end
        end else if (k_r == lim_r) begin
          if (out_free) begin
            load      = 1'b1;
            ld_st     = ST_NOTFOUND;
            state_nxt = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(k1_w);
          k_nxt     = IW'(k1_w);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load    = 1'b1;
          ld_val  = val_t'(mem_rdata);
          ld_pos  = POS_W'(k1_w);
          ld_last = bwd_r ? (k_r == '0) : (k_r == lim_r);
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = bwd_r ? k_r - IW'(1) : IW'(k1_w);
            k_nxt     = bwd_r ? k_r - IW'(1) : IW'(k1_w);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          load      = 1'b1;
          ld_st     = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    idx_r <= idx_nxt;
    lim_r <= lim_nxt;
    val_r <= val_nxt;
    bwd_r <= bwd_nxt;
    st_r  <= st_nxt;
    if (load) begin
      ost_r   <= ld_st;
      oval_r  <= ld_val;
      opos_r  <= ld_pos;
      olast_r <= ld_last;
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_value          = oval_r;
  assign out_found_position = opos_r;
  assign out_last           = olast_r;

endmodule

>>> hw/rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// ordered list of up to CAPACITY signed 32-bit values in a single memory
//
// in_* transfers carry an operation, a 1-based position and a value; out_*
// transfers carry status, value, position and a last mark. Inserts, deletes
// and searches give one result; a dump gives one result per element, the
// final one with out_last set. Undefined operation codes give no result.
// One item is worked at a time: in_ready is high only while the sequencer
// is idle. An insert at position p of a list of n elements moves the elements
// from the tail down to p with one memory read and write each, then places
// the value and posts the result; a delete moves the elements behind p one
// place forward, then posts; a search reads from the head until a match or
// the tail, and a dump reads each element in turn. The next input transfer
// can follow in the cycle after the final result is posted. Element memory
// read data is registered, and each walk step waits on its read.
// Results leave through an output register; while the receiver stalls the
// sequencer holds its place and no memory access is lost. Reset empties the
// list and drops a pending result; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bole_pkg::func_t    in_func,
  input  bole_pkg::pos_t     in_position,
  input  bole_pkg::val_t     in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output bole_pkg::status_t  out_status,
  output bole_pkg::val_t     out_value,
  output bole_pkg::pos_t     out_found_position,
  output logic               out_last
);
  import bole_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  bole_ctrl #(
    .CAPACITY(CAPACITY),
    .IW      (IW),
    .CW      (CW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_value         (out_value),
    .out_found_position(out_found_position),
    .out_last          (out_last),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  bole_mem #(
    .DEPTH(CAPACITY),
    .AW   (IW),
    .DW   (VAL_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

>>> hw/rtl/bole_chk.sv
// ----------------------------------------------------------------------------
// bole_chk
// port-level checks of the bounded ordered list engine
// ----------------------------------------------------------------------------
module bole_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bole_pkg::status_t  out_status,
  input bole_pkg::val_t     out_value,
  input bole_pkg::pos_t     out_found_position,
  input logic               out_last
);
  import bole_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_value) && $stable(out_found_position) && $stable(out_last))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error status inside a run");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0 && out_found_position == '0)
    else $error("error result carries data");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_EMPTY ||
      out_status == ST_BADPOS || out_status == ST_FULL || out_status == ST_NOTFOUND)
    else $error("undefined status code");

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (.*);
